FILE: hw/rtl/assert_macros.svh
// assertion helpers used by fesg_math
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define FESG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fesg assertion failed");

// next-cycle implication, held off during reset
`define FESG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fesg assertion failed");

`endif

FILE: hw/rtl/fesg_pkg.sv
`timescale 1ns / 1ps

package fesg_pkg;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quad;

    typedef enum logic [1:0] {
        CFG_AMP_X  = 2'd0,
        CFG_AMP_Y  = 2'd1,
        CFG_RATE   = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_quad       quad;
        logic [29:0] frac;
    } t_angle;

    // turns per microsecond per rad/s, scaled by 2^56
    localparam logic [33:0] TURN_SCALE = 34'd11468322278;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam int MAX_STEPS = 32;

    localparam logic [31:0] ATAN_TURNS [MAX_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // scale by 2^-sh, rounding half away from zero
    function automatic logic signed [65:0] round_shift(input logic signed [65:0] p,
                                                       input int unsigned sh);
        logic [65:0] m;
        logic [65:0] r;
        m = p[65] ? 66'(-p) : 66'(p);
        r = (m + (66'd1 << (sh - 1))) >> sh;
        return p[65] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [43:0] v);
        if (v > 44'sd2147483647) begin
            return 32'h7FFFFFFF;
        end else if (v < -44'sd2147483648) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: hw/rtl/fesg_phase.sv
`timescale 1ns / 1ps

module fesg_phase #(
    parameter int TIME_WIDTH = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [TIME_WIDTH-1:0] i_time,
    input  logic [27:0]           i_rate,
    output logic                  o_valid,
    output fesg_pkg::t_angle      o_angle
);

    logic        r1_v, r2_v, r3_v, r4_v, r5_v;
    logic [63:0] r1_t, r2_t;
    logic [44:0] r1_pk0, r1_pk1;
    logic [45:0] r2_inc;
    logic [38:0] r3_pp [2][4];
    logic [63:0] r4_row [2];
    fesg_pkg::t_angle r5_angle;

    logic [62:0] n_sum;
    logic [63:0] n_row [2];
    logic [63:0] n_phase;

    always_comb begin
        n_sum = 63'(r1_pk0) + (63'(r1_pk1) << 17) + 63'd32768;
        for (int i = 0; i < 2; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < 4; j++) begin
                n_row[i] = n_row[i] + (64'(r3_pp[i][j]) << (16 * j));
            end
        end
        n_phase = r4_row[0] + (r4_row[1] << 23);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_t   <= 64'(i_time);
        r1_pk0 <= i_rate * fesg_pkg::TURN_SCALE[16:0];
        r1_pk1 <= i_rate * fesg_pkg::TURN_SCALE[33:17];
        r2_t   <= r1_t;
        r2_inc <= n_sum[61:16];
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 4; j++) begin
                r3_pp[i][j] <= r2_inc[23*i +: 23] * r2_t[16*j +: 16];
            end
        end
        r4_row <= n_row;
        r5_angle.quad <= fesg_pkg::t_quad'(n_phase[63:62]);
        r5_angle.frac <= n_phase[61:32];
    end

    assign o_valid = r5_v;
    assign o_angle = r5_angle;

endmodule

FILE: hw/rtl/fesg_cordic.sv
`timescale 1ns / 1ps

module fesg_cordic #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  fesg_pkg::t_angle        i_angle,
    output logic                    o_valid,
    output fesg_pkg::t_quad         o_quad,
    output logic signed [33:0]      o_x,
    output logic signed [33:0]      o_y
);

    logic [CORDIC_STEPS-1:0] r_v;
    logic signed [33:0]      r_x [CORDIC_STEPS];
    logic signed [33:0]      r_y [CORDIC_STEPS];
    logic signed [33:0]      r_z [CORDIC_STEPS];
    fesg_pkg::t_quad         r_q [CORDIC_STEPS];

    logic signed [33:0]      n_x [CORDIC_STEPS];
    logic signed [33:0]      n_y [CORDIC_STEPS];
    logic signed [33:0]      n_z [CORDIC_STEPS];
    fesg_pkg::t_quad         n_q [CORDIC_STEPS];

    // one micro-rotation per stage
    always_comb begin
        logic signed [33:0] xi, yi, zi, ang;
        for (int g = 0; g < CORDIC_STEPS; g++) begin
            if (g == 0) begin
                xi = fesg_pkg::CORDIC_X0;
                yi = '0;
                zi = $signed({4'b0, i_angle.frac});
                n_q[g] = i_angle.quad;
            end else begin
                xi = r_x[g-1];
                yi = r_y[g-1];
                zi = r_z[g-1];
                n_q[g] = r_q[g-1];
            end
            ang = $signed({2'b00, fesg_pkg::ATAN_TURNS[g]});
            if (!zi[33]) begin
                n_x[g] = xi - (yi >>> g);
                n_y[g] = yi + (xi >>> g);
                n_z[g] = zi - ang;
            end else begin
                n_x[g] = xi + (yi >>> g);
                n_y[g] = yi - (xi >>> g);
                n_z[g] = zi + ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[CORDIC_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_q <= n_q;
    end

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_quad  = r_q[CORDIC_STEPS-1];
    assign o_x     = r_x[CORDIC_STEPS-1];
    assign o_y     = r_y[CORDIC_STEPS-1];

endmodule

FILE: hw/rtl/fesg_math.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fesg_math (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  fesg_pkg::t_quad     i_quad,
    input  logic signed [33:0]  i_x,
    input  logic signed [33:0]  i_y,
    input  logic signed [31:0]  i_amp_x,
    input  logic signed [31:0]  i_amp_y,
    input  logic [27:0]         i_rate,
    input  logic signed [31:0]  i_height,
    output logic                o_valid,
    output logic [31:0]         o_pos_x,
    output logic [31:0]         o_pos_y,
    output logic [31:0]         o_pos_z,
    output logic [31:0]         o_vel_x,
    output logic [31:0]         o_vel_y,
    output logic [31:0]         o_acc_x,
    output logic [31:0]         o_acc_y
);

    function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
        if (v > 34'sd1073741824) begin
            return 32'sd1073741824;
        end else if (v < -34'sd1073741824) begin
            return -32'sd1073741824;
        end
        return v[31:0];
    endfunction

    logic r1_v, r2_v, r3_v, r4_v, r5_v;

    logic signed [31:0] r1_s, r1_c;
    logic signed [31:0] r2_s, r2_c, r2_sc, r2_cc, r2_ss;
    logic [32:0]        r2_w2;
    logic signed [43:0] r2_px, r3_px, r4_px;
    logic signed [29:0] r3_wc, r3_wd;
    logic signed [33:0] r3_w2s, r3_w2sc;
    logic signed [43:0] r3_py, r4_py;
    logic signed [43:0] r4_vx, r4_vy, r4_ax, r4_ay;
    logic [31:0]        r5_px, r5_py, r5_pz, r5_vx, r5_vy, r5_ax, r5_ay;

    logic signed [33:0] n_c, n_s;
    logic signed [28:0] w_rate;
    logic signed [32:0] w_d;

    assign w_rate = $signed({1'b0, i_rate});
    assign w_d    = 33'(r2_cc) - 33'(r2_ss);

    // rotate the first-quadrant result into place
    always_comb begin
        unique case (i_quad)
            fesg_pkg::QUAD_I: begin
                n_c = i_x;
                n_s = i_y;
            end
            fesg_pkg::QUAD_II: begin
                n_c = -i_y;
                n_s = i_x;
            end
            fesg_pkg::QUAD_III: begin
                n_c = -i_x;
                n_s = -i_y;
            end
            fesg_pkg::QUAD_IV: begin
                n_c = i_y;
                n_s = -i_x;
            end
            default: begin
                n_c = i_x;
                n_s = i_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_s <= clamp_unit(n_s);
        r1_c <= clamp_unit(n_c);

        r2_s  <= r1_s;
        r2_c  <= r1_c;
        r2_sc <= 32'(fesg_pkg::round_shift(66'(r1_s * r1_c), 30));
        r2_cc <= 32'(fesg_pkg::round_shift(66'(r1_c * r1_c), 30));
        r2_ss <= 32'(fesg_pkg::round_shift(66'(r1_s * r1_s), 30));
        r2_w2 <= 33'(fesg_pkg::round_shift(66'(w_rate * w_rate), 24));
        r2_px <= 44'(fesg_pkg::round_shift(66'(i_amp_x * r1_s), 30));

        r3_wc   <= 30'(fesg_pkg::round_shift(66'(w_rate * r2_c), 30));
        r3_wd   <= 30'(fesg_pkg::round_shift(66'(w_rate * w_d), 30));
        r3_w2s  <= 34'(fesg_pkg::round_shift(66'($signed({1'b0, r2_w2}) * r2_s), 30));
        r3_w2sc <= 34'(fesg_pkg::round_shift(66'($signed({1'b0, r2_w2}) * r2_sc), 30));
        r3_py   <= 44'(fesg_pkg::round_shift(66'(i_amp_y * r2_sc), 30));
        r3_px   <= r2_px;

        r4_vx <= 44'(fesg_pkg::round_shift(66'(i_amp_x * r3_wc), 24));
        r4_vy <= 44'(fesg_pkg::round_shift(66'(i_amp_y * r3_wd), 24));
        r4_ax <= -44'(fesg_pkg::round_shift(66'(i_amp_x * r3_w2s), 24));
        r4_ay <= -44'(fesg_pkg::round_shift(66'(i_amp_y * r3_w2sc), 22));
        r4_px <= r3_px;
        r4_py <= r3_py;

        r5_px <= fesg_pkg::sat32(r4_px);
        r5_py <= fesg_pkg::sat32(r4_py);
        r5_pz <= i_height;
        r5_vx <= fesg_pkg::sat32(r4_vx);
        r5_vy <= fesg_pkg::sat32(r4_vy);
        r5_ax <= fesg_pkg::sat32(r4_ax);
        r5_ay <= fesg_pkg::sat32(r4_ay);
    end

    assign o_valid = r5_v;
    assign o_pos_x = r5_px;
    assign o_pos_y = r5_py;
    assign o_pos_z = r5_pz;
    assign o_vel_x = r5_vx;
    assign o_vel_y = r5_vy;
    assign o_acc_x = r5_ax;
    assign o_acc_y = r5_ay;

    `FESG_ASSERT_IMP(a_sin_range, i_clk, i_rst_n, r1_v, (r1_s <= 32'sd1073741824) && (r1_s >= -32'sd1073741824))
    `FESG_ASSERT_IMP(a_cos_range, i_clk, i_rst_n, r1_v, (r1_c <= 32'sd1073741824) && (r1_c >= -32'sd1073741824))
    `FESG_ASSERT_IMP(a_valid_chain, i_clk, i_rst_n, r5_v, $past(i_valid, 5))
    `FESG_ASSERT_NXT(a_valid_flow, i_clk, i_rst_n, r2_v, r3_v)

endmodule

FILE: hw/rtl/figure_eight_setpoint_generator_core.sv
`timescale 1ns / 1ps
// throughput: one item per cycle; busy is always low
// phase stage first, then one cordic rotation per stage, then the products
// results are shown for one cycle on o_valid; the receiver cannot stall
// reset clears all valid bits and loads the default registers

module figure_eight_setpoint_generator_core #(
    parameter int TIME_WIDTH   = 40,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [TIME_WIDTH-1:0] i_elapsed_us,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_wdata,
    output logic                  o_valid,
    output logic signed [31:0]    o_pos_x,
    output logic signed [31:0]    o_pos_y,
    output logic signed [31:0]    o_pos_z,
    output logic signed [31:0]    o_vel_x,
    output logic signed [31:0]    o_vel_y,
    output logic signed [31:0]    o_acc_x,
    output logic signed [31:0]    o_acc_y
);

    logic signed [31:0] r_amp_x, r_amp_y, r_height;
    logic [27:0]        r_rate;

    logic               ph_valid;
    fesg_pkg::t_angle   ph_angle;
    logic               cr_valid;
    fesg_pkg::t_quad    cr_quad;
    logic signed [33:0] cr_x, cr_y;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_x  <= 32'sd131072;
            r_amp_y  <= 32'sd65536;
            r_rate   <= 28'd6710886;
            r_height <= -32'sd327680;
        end else if (i_cfg_we) begin
            unique case (fesg_pkg::t_cfg_reg'(i_cfg_idx))
                fesg_pkg::CFG_AMP_X:  r_amp_x  <= i_cfg_wdata;
                fesg_pkg::CFG_AMP_Y:  r_amp_y  <= i_cfg_wdata;
                fesg_pkg::CFG_RATE:   r_rate   <= i_cfg_wdata[27:0];
                fesg_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    fesg_phase #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_time  (i_elapsed_us),
        .i_rate  (r_rate),
        .o_valid (ph_valid),
        .o_angle (ph_angle)
    );

    fesg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ph_valid),
        .i_angle (ph_angle),
        .o_valid (cr_valid),
        .o_quad  (cr_quad),
        .o_x     (cr_x),
        .o_y     (cr_y)
    );

    fesg_math u_math (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cr_valid),
        .i_quad   (cr_quad),
        .i_x      (cr_x),
        .i_y      (cr_y),
        .i_amp_x  (r_amp_x),
        .i_amp_y  (r_amp_y),
        .i_rate   (r_rate),
        .i_height (r_height),
        .o_valid  (o_valid),
        .o_pos_x  (o_pos_x),
        .o_pos_y  (o_pos_y),
        .o_pos_z  (o_pos_z),
        .o_vel_x  (o_vel_x),
        .o_vel_y  (o_vel_y),
        .o_acc_x  (o_acc_x),
        .o_acc_y  (o_acc_y)
    );

endmodule

FILE: verif/tb_figure_eight_setpoint_generator_core.sv
`timescale 1ns / 1ps

module tb_figure_eight_setpoint_generator_core;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
    } t_setpoint;

    localparam int STEPS = 24;
    localparam int LATENCY = STEPS + 10;
    localparam int STALL_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [39:0] i_elapsed_us = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = fesg_pkg::CFG_AMP_X;
    logic [31:0] i_cfg_wdata = '0;
    logic        o_valid;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_acc_x, o_acc_y;

    figure_eight_setpoint_generator_core #(
        .TIME_WIDTH(40),
        .CORDIC_STEPS(STEPS)
    ) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_elapsed_us(i_elapsed_us), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata), .o_valid(o_valid), .o_pos_x(o_pos_x),
        .o_pos_y(o_pos_y), .o_pos_z(o_pos_z), .o_vel_x(o_vel_x), .o_vel_y(o_vel_y),
        .o_acc_x(o_acc_x), .o_acc_y(o_acc_y)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the block's registers
    longint      amp_x = 131072;
    longint      amp_y = 65536;
    logic [27:0] rate = 28'd6710886;
    longint      height = -327680;

    logic [39:0] pending_times[$];
    t_setpoint   expected_setpoints[$];
    int          idle_pct = 25;
    int          errors = 0;
    int          quiet_cycles = 0;

    // exact product scaled by 2^-sh, rounded half away from zero, magnitude capped at 2^62
    function automatic longint scale_mul(longint a, longint b, int sh);
        logic [63:0]  ua, ub;
        logic [127:0] p;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > (128'd1 << 62)) p = 128'd1 << 62;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic t_setpoint figure_eight_at(logic [39:0] t);
        logic [63:0]     inc, phase;
        fesg_pkg::t_quad quad;
        longint          x, y, z, dx, dy, s, c, w, sc, d, w2;
        t_setpoint       r;
        inc = ({36'd0, rate} * 64'(fesg_pkg::TURN_SCALE) + 64'd32768) >> 16;
        phase = inc * {24'd0, t};
        quad = fesg_pkg::t_quad'(phase[63:62]);
        x = 652032874;
        y = 0;
        z = longint'(phase[61:32]);
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(fesg_pkg::ATAN_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(fesg_pkg::ATAN_TURNS[i]);
            end
        end
        case (quad)
            fesg_pkg::QUAD_I:   begin c = x;  s = y;  end
            fesg_pkg::QUAD_II:  begin c = -y; s = x;  end
            fesg_pkg::QUAD_III: begin c = -x; s = -y; end
            default:            begin c = y;  s = -x; end
        endcase
        if (s > 1073741824) s = 1073741824;
        if (s < -1073741824) s = -1073741824;
        if (c > 1073741824) c = 1073741824;
        if (c < -1073741824) c = -1073741824;
        w = longint'(rate);
        sc = scale_mul(s, c, 30);
        d = scale_mul(c, c, 30) - scale_mul(s, s, 30);
        w2 = scale_mul(w, w, 24);
        r.pos_x = clip32(scale_mul(amp_x, s, 30));
        r.pos_y = clip32(scale_mul(amp_y, sc, 30));
        r.pos_z = clip32(height);
        r.vel_x = clip32(scale_mul(amp_x, scale_mul(w, c, 30), 24));
        r.vel_y = clip32(scale_mul(amp_y, scale_mul(w, d, 30), 24));
        r.acc_x = clip32(-scale_mul(amp_x, scale_mul(w2, s, 30), 24));
        r.acc_y = clip32(-scale_mul(amp_y, scale_mul(w2, sc, 30), 22));
        return r;
    endfunction

    // driver: one nonblocking write of start per edge
    always @(posedge i_clk) begin
        if (start && !busy) expected_setpoints.push_back(figure_eight_at(i_elapsed_us));
        if (i_rst_n && pending_times.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            start <= 1'b1;
            i_elapsed_us <= pending_times.pop_front();
        end else begin
            start <= 1'b0;
        end
    end

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_setpoint e;
        if (i_rst_n && o_valid) begin
            if (expected_setpoints.size() == 0) begin
                errors++;
                $display("%0t unexpected item: expected none got pos_x %0d", $time, o_pos_x);
            end else begin
                e = expected_setpoints.pop_front();
                check_field("pos_x", e.pos_x, o_pos_x);
                check_field("pos_y", e.pos_y, o_pos_y);
                check_field("pos_z", e.pos_z, o_pos_z);
                check_field("vel_x", e.vel_x, o_vel_x);
                check_field("vel_y", e.vel_y, o_vel_y);
                check_field("acc_x", e.acc_x, o_acc_x);
                check_field("acc_y", e.acc_y, o_acc_y);
            end
        end
    end

    // watchdog on cycles with no item moving either way
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(fesg_pkg::t_cfg_reg idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        case (idx)
            fesg_pkg::CFG_AMP_X:  amp_x = longint'(signed'(v));
            fesg_pkg::CFG_AMP_Y:  amp_y = longint'(signed'(v));
            fesg_pkg::CFG_RATE:   rate = v[27:0];
            fesg_pkg::CFG_HEIGHT: height = longint'(signed'(v));
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_times.size() > 0 || start || expected_setpoints.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [39:0] random_time();
        case ($urandom_range(0, 3))
            0: return 40'($urandom_range(0, 2000000));
            1: return 40'({$urandom, $urandom});
            2: return 40'($urandom) * 40'd97;
            default: return ~40'($urandom_range(0, 1000));
        endcase
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults, time extremes and eighth turns
        pending_times.push_back(40'd0);
        pending_times.push_back(40'd1);
        pending_times.push_back(40'hFF_FFFF_FFFF);
        pending_times.push_back(40'hAA_AAAA_AAAA);
        pending_times.push_back(40'h55_5555_5555);
        pending_times.push_back(40'h80_0000_0000);
        for (int k = 1; k <= 8; k++) pending_times.push_back(40'(k) * 40'd1963495);
        drain();

        for (int ph = 1; ph <= 8; ph++) begin
            idle_pct = (ph <= 3) ? 25 : (ph <= 6) ? 61 : 0;
            case (ph)
                1: begin
                    write_reg(fesg_pkg::CFG_AMP_X, 32'h7FFFFFFF);
                    write_reg(fesg_pkg::CFG_AMP_Y, 32'h80000000);
                    write_reg(fesg_pkg::CFG_RATE, 32'hFFFFFFFF);
                    write_reg(fesg_pkg::CFG_HEIGHT, 32'h7FFFFFFF);
                end
                2: begin
                    write_reg(fesg_pkg::CFG_AMP_X, 32'h80000000);
                    write_reg(fesg_pkg::CFG_AMP_Y, 32'h7FFFFFFF);
                    write_reg(fesg_pkg::CFG_RATE, 32'h0);
                    write_reg(fesg_pkg::CFG_HEIGHT, 32'h80000000);
                end
                default: begin
                    write_reg(fesg_pkg::CFG_AMP_X, $urandom);
                    write_reg(fesg_pkg::CFG_AMP_Y, $urandom);
                    write_reg(fesg_pkg::CFG_RATE, ($urandom_range(0, 1) != 0) ? $urandom
                                                        : $urandom_range(0, 50000000));
                    write_reg(fesg_pkg::CFG_HEIGHT, $urandom);
                end
            endcase
            if (ph <= 2) begin
                pending_times.push_back(40'd0);
                pending_times.push_back(40'hFF_FFFF_FFFF);
            end
            for (int n = 0; n < 80; n++) pending_times.push_back(random_time());
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
